### hdl/yls_pkg.sv
// yls_pkg: shared types, constants and the class color decoder for the
// yuv lookup-table color segmenter. No dependencies.

package yls_pkg;

  localparam int CLASS_BITS  = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int INDEX_BITS  = $clog2(TABLE_DEPTH);

  typedef logic [CLASS_BITS-1:0] class_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [7:0]            byte_t;

  typedef enum logic [1:0] {
    FUNC_PROCESS = 2'd0,
    FUNC_WR_LUMA = 2'd1,
    FUNC_WR_U    = 2'd2,
    FUNC_WR_V    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MODE_OVERWRITE    = 2'd0,
    MODE_OVERWRITE_NZ = 2'd1,
    MODE_BLEND        = 2'd2,
    MODE_PASS         = 2'd3
  } mode_e;

  typedef struct packed {
    byte_t y;
    byte_t u;
    byte_t v;
  } color_t;

  // table write request from the top level to the table memories
  typedef struct packed {
    logic   wr_luma;
    logic   wr_u;
    logic   wr_v;
    index_t index;
    class_t entry;
  } table_wr_t;

  // read request: one address per table
  typedef struct packed {
    logic   en;
    index_t luma_addr;
    index_t u_addr;
    index_t v_addr;
  } table_rd_t;

  function automatic color_t pick_color(input class_t cls);
    color_t c;
    case (cls)
      class_t'(0): c = '{y: 8'd0,   u: 8'd128, v: 8'd128};
      class_t'(1): c = '{y: 8'd76,  u: 8'd85,  v: 8'd255};
      class_t'(2): c = '{y: 8'd30,  u: 8'd255, v: 8'd107};
      class_t'(4): c = '{y: 8'd152, u: 8'd42,  v: 8'd202};
      class_t'(8): c = '{y: 8'd226, u: 8'd1,   v: 8'd149};
      default:     c = '{y: 8'd255, u: 8'd128, v: 8'd128};
    endcase
    return c;
  endfunction

endpackage

### hdl/yls_ifs.sv
// yls_ifs: valid/ready channel interfaces for the segmenter: input words,
// result words and the display mode register write. Depends on yls_pkg.

interface yls_pix_if;
  logic             valid;
  logic             ready;
  yls_pkg::func_e   func;
  yls_pkg::byte_t   first_luma;
  yls_pkg::byte_t   chroma_u;
  yls_pkg::byte_t   second_luma;
  yls_pkg::byte_t   chroma_v;
  yls_pkg::byte_t   table_index;
  yls_pkg::byte_t   table_entry;

  modport source (output valid, func, first_luma, chroma_u, second_luma, chroma_v,
                  table_index, table_entry, input ready);
  modport sink (input valid, func, first_luma, chroma_u, second_luma, chroma_v,
                table_index, table_entry, output ready);
endinterface

interface yls_res_if;
  logic           valid;
  logic           ready;
  yls_pkg::byte_t first_luma_out;
  yls_pkg::byte_t chroma_u_out;
  yls_pkg::byte_t second_luma_out;
  yls_pkg::byte_t chroma_v_out;
  yls_pkg::byte_t class_mask;

  modport source (output valid, first_luma_out, chroma_u_out, second_luma_out,
                  chroma_v_out, class_mask, input ready);
  modport sink (input valid, first_luma_out, chroma_u_out, second_luma_out,
                chroma_v_out, class_mask, output ready);
endinterface

interface yls_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hdl/yuv_lut_color_segmenter.sv
// yuv_lut_color_segmenter: top level of the yuy2 lookup-table segmenter.
// Depends on yls_pkg, yls_ifs and yls_tables.
//
// Usage:
//   pix  : input words. func selects a macropixel to classify or a write of
//          one entry of the luma, u or v class table (table_index, table_entry).
//          Table writes produce no result word.
//   res  : one result word per macropixel: the recolored bytes and the ANDed
//          class mask of the three table entries read at Y0, U and V.
//   cfg  : display mode register write (overwrite, overwrite nonzero class,
//          blend half, pass); always ready, write it only while idle.
// Throughput is one word per cycle while res is not stalled: each table is
// its own memory with one read and one write port, and reads and writes
// never share a cycle. The memory read registers at the input accept edge,
// and the class decode and recolor load the output register, which drives
// res.valid, when the read stage advances.
// Reset clears the pipeline valids and the mode (overwrite); table contents
// are unknown until written. When res stalls, the read stage holds its word
// and pix.ready drops only when both the read stage and output are full.

module yuv_lut_color_segmenter (
  input  logic      clk,
  input  logic      rst,
  yls_pix_if.sink   pix,
  yls_res_if.source res,
  yls_cfg_if.sink   cfg
);

  yls_pkg::mode_e     mode;
  yls_pkg::table_wr_t tbl_wr;
  yls_pkg::table_rd_t tbl_rd;
  yls_pkg::class_t    luma_cls;
  yls_pkg::class_t    u_cls;
  yls_pkg::class_t    v_cls;

  logic           in_acc;
  logic           is_proc;
  logic           s1_valid;
  logic           s1_adv;
  yls_pkg::byte_t s1_y0;
  yls_pkg::byte_t s1_u;
  yls_pkg::byte_t s1_y1;
  yls_pkg::byte_t s1_v;

  yls_pkg::class_t cls;
  yls_pkg::color_t color;
  yls_pkg::byte_t  y0_next;
  yls_pkg::byte_t  u_next;
  yls_pkg::byte_t  y1_next;
  yls_pkg::byte_t  v_next;

  logic           out_valid;
  yls_pkg::byte_t out_y0;
  yls_pkg::byte_t out_u;
  yls_pkg::byte_t out_y1;
  yls_pkg::byte_t out_v;
  yls_pkg::byte_t out_cls;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= yls_pkg::MODE_OVERWRITE;
    end else if (cfg.valid && cfg.ready) begin
      mode <= yls_pkg::mode_e'(cfg.data);
    end
  end

  // handshake
  assign s1_adv    = !out_valid || res.ready;
  assign pix.ready = !s1_valid || s1_adv;
  assign in_acc    = pix.valid && pix.ready;
  assign is_proc   = pix.func == yls_pkg::FUNC_PROCESS;

  always_comb begin
    tbl_wr.wr_luma = in_acc && pix.func == yls_pkg::FUNC_WR_LUMA;
    tbl_wr.wr_u    = in_acc && pix.func == yls_pkg::FUNC_WR_U;
    tbl_wr.wr_v    = in_acc && pix.func == yls_pkg::FUNC_WR_V;
    tbl_wr.index   = yls_pkg::index_t'(pix.table_index);
    tbl_wr.entry   = yls_pkg::class_t'(pix.table_entry);
    tbl_rd.en        = in_acc && is_proc;
    tbl_rd.luma_addr = yls_pkg::index_t'(pix.first_luma);
    tbl_rd.u_addr    = yls_pkg::index_t'(pix.chroma_u);
    tbl_rd.v_addr    = yls_pkg::index_t'(pix.chroma_v);
  end

  yls_tables u_tables (
    .clk       (clk),
    .wr        (tbl_wr),
    .rd        (tbl_rd),
    .luma_data (luma_cls),
    .u_data    (u_cls),
    .v_data    (v_cls)
  );

  // read stage: macropixel bytes wait here beside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= is_proc;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_proc) begin
      s1_y0 <= pix.first_luma;
      s1_u  <= pix.chroma_u;
      s1_y1 <= pix.second_luma;
      s1_v  <= pix.chroma_v;
    end
  end

  // classify and recolor
  always_comb begin
    cls   = luma_cls & u_cls & v_cls;
    color = yls_pkg::pick_color(cls);
    y0_next = s1_y0;
    u_next  = s1_u;
    y1_next = s1_y1;
    v_next  = s1_v;
    case (mode)
      yls_pkg::MODE_OVERWRITE: begin
        y0_next = color.y;
        u_next  = color.u;
        y1_next = color.y;
        v_next  = color.v;
      end
      yls_pkg::MODE_OVERWRITE_NZ: begin
        if (cls != '0) begin
          y0_next = color.y;
          u_next  = color.u;
          y1_next = color.y;
          v_next  = color.v;
        end
      end
      yls_pkg::MODE_BLEND: begin
        // halves never carry out of the byte
        y0_next = (s1_y0 >> 1) + (color.y >> 1);
        u_next  = (s1_u >> 1) + (color.u >> 1);
        y1_next = (s1_y1 >> 1) + (color.y >> 1);
        v_next  = (s1_v >> 1) + (color.v >> 1);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_y0  <= y0_next;
      out_u   <= u_next;
      out_y1  <= y1_next;
      out_v   <= v_next;
      out_cls <= 8'(cls);
    end
  end

  assign res.valid           = out_valid;
  assign res.first_luma_out  = out_y0;
  assign res.chroma_u_out    = out_u;
  assign res.second_luma_out = out_y1;
  assign res.chroma_v_out    = out_v;
  assign res.class_mask      = out_cls;

  // checks
  a_proc_fills_stage: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_proc) |=> s1_valid)
    else $error("macropixel accepted but read stage empty");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !is_proc) |=> !s1_valid)
    else $error("table write entered the read stage");

  a_read_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(luma_cls) && $stable(u_cls)
                               && $stable(v_cls)))
    else $error("stalled read stage lost its table data");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !res.ready) |-> !pix.ready)
    else $error("input accepted with both stages full and output stalled");

endmodule

### hdl/yls_tables.sv
// yls_tables: the three 256-entry class mask memories (luma, u, v), one
// write port shared by all and a registered read per table. Depends on yls_pkg.

module yls_tables (
  input  logic                clk,
  input  yls_pkg::table_wr_t  wr,
  input  yls_pkg::table_rd_t  rd,
  output yls_pkg::class_t     luma_data,
  output yls_pkg::class_t     u_data,
  output yls_pkg::class_t     v_data
);

  yls_pkg::class_t luma_mem [yls_pkg::TABLE_DEPTH];
  yls_pkg::class_t u_mem    [yls_pkg::TABLE_DEPTH];
  yls_pkg::class_t v_mem    [yls_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.wr_luma) begin
      luma_mem[wr.index] <= wr.entry;
    end
    if (wr.wr_u) begin
      u_mem[wr.index] <= wr.entry;
    end
    if (wr.wr_v) begin
      v_mem[wr.index] <= wr.entry;
    end
  end

  // read data holds while the next stage is stalled
  always_ff @(posedge clk) begin
    if (rd.en) begin
      luma_data <= luma_mem[rd.luma_addr];
      u_data    <= u_mem[rd.u_addr];
      v_data    <= v_mem[rd.v_addr];
    end
  end

endmodule

### verif/yls_segment_check.sv
// yls_segment_check: watches the pix, res and cfg channels of the segmenter,
// keeps its own class tables and display mode, predicts every result word and
// compares it field by field. Depends on yls_pkg and yls_ifs.

module yls_segment_check (
  input  logic        clk,
  input  logic        rst,
  yls_pix_if          pix,
  yls_res_if          res,
  yls_cfg_if          cfg,
  output int unsigned fails,
  output int unsigned waiting,
  output int unsigned checked,
  output int unsigned table_writes
);

  typedef struct packed {
    yls_pkg::byte_t y0;
    yls_pkg::byte_t u;
    yls_pkg::byte_t y1;
    yls_pkg::byte_t v;
    yls_pkg::byte_t cls;
  } segmented_t;

  yls_pkg::class_t luma_tbl [yls_pkg::TABLE_DEPTH];
  yls_pkg::class_t u_tbl    [yls_pkg::TABLE_DEPTH];
  yls_pkg::class_t v_tbl    [yls_pkg::TABLE_DEPTH];
  yls_pkg::mode_e  mode;
  segmented_t      expected_px [$];

  initial begin
    fails        = 0;
    waiting      = 0;
    checked      = 0;
    table_writes = 0;
    mode         = yls_pkg::MODE_OVERWRITE;
  end

  function automatic yls_pkg::color_t display_color(yls_pkg::class_t cls);
    yls_pkg::color_t c;
    case (cls)
      yls_pkg::class_t'(0): c = '{y: 8'd0,   u: 8'd128, v: 8'd128};
      yls_pkg::class_t'(1): c = '{y: 8'd76,  u: 8'd85,  v: 8'd255};
      yls_pkg::class_t'(2): c = '{y: 8'd30,  u: 8'd255, v: 8'd107};
      yls_pkg::class_t'(4): c = '{y: 8'd152, u: 8'd42,  v: 8'd202};
      yls_pkg::class_t'(8): c = '{y: 8'd226, u: 8'd1,   v: 8'd149};
      default:              c = '{y: 8'd255, u: 8'd128, v: 8'd128};
    endcase
    return c;
  endfunction

  function automatic segmented_t segment(yls_pkg::byte_t y0, yls_pkg::byte_t u,
                                         yls_pkg::byte_t y1, yls_pkg::byte_t v);
    yls_pkg::class_t cls;
    yls_pkg::color_t c;
    segmented_t      s;
    cls = luma_tbl[y0] & u_tbl[u] & v_tbl[v];
    c   = display_color(cls);
    s   = '{y0: y0, u: u, y1: y1, v: v, cls: yls_pkg::byte_t'(cls)};
    if (mode == yls_pkg::MODE_OVERWRITE ||
        (mode == yls_pkg::MODE_OVERWRITE_NZ && cls != '0)) begin
      s.y0 = c.y;
      s.u  = c.u;
      s.y1 = c.y;
      s.v  = c.v;
    end else if (mode == yls_pkg::MODE_BLEND) begin
      s.y0 = (y0 >> 1) + (c.y >> 1);
      s.u  = (u >> 1) + (c.u >> 1);
      s.y1 = (y1 >> 1) + (c.y >> 1);
      s.v  = (v >> 1) + (c.v >> 1);
    end
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(string name, yls_pkg::byte_t got, yls_pkg::byte_t want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    segmented_t want;
    if (rst) begin
      mode = yls_pkg::MODE_OVERWRITE;
      expected_px.delete();
    end else begin
      if (cfg.valid && cfg.ready) mode = yls_pkg::mode_e'(cfg.data);
      // results first, so a word cannot match an item accepted at the same edge
      if (res.valid && res.ready) begin
        if (expected_px.size() == 0) begin
          report_mismatch($sformatf("result word %h %h %h %h class %h with nothing expected",
                                    res.first_luma_out, res.chroma_u_out,
                                    res.second_luma_out, res.chroma_v_out, res.class_mask));
        end else begin
          want = expected_px.pop_front();
          checked++;
          check_field("first_luma_out", res.first_luma_out, want.y0);
          check_field("chroma_u_out", res.chroma_u_out, want.u);
          check_field("second_luma_out", res.second_luma_out, want.y1);
          check_field("chroma_v_out", res.chroma_v_out, want.v);
          check_field("class_mask", res.class_mask, want.cls);
        end
      end
      if (pix.valid && pix.ready) begin
        case (pix.func)
          yls_pkg::FUNC_PROCESS: begin
            expected_px.push_back(segment(pix.first_luma, pix.chroma_u,
                                          pix.second_luma, pix.chroma_v));
          end
          yls_pkg::FUNC_WR_LUMA: begin
            luma_tbl[pix.table_index] = yls_pkg::class_t'(pix.table_entry);
            table_writes++;
          end
          yls_pkg::FUNC_WR_U: begin
            u_tbl[pix.table_index] = yls_pkg::class_t'(pix.table_entry);
            table_writes++;
          end
          yls_pkg::FUNC_WR_V: begin
            v_tbl[pix.table_index] = yls_pkg::class_t'(pix.table_entry);
            table_writes++;
          end
          default: ;
        endcase
      end
    end
    waiting = expected_px.size();
  end

endmodule

### verif/yuv_lut_color_segmenter_test.sv
// yuv_lut_color_segmenter_test: drives table writes, macropixels and display
// mode writes into the segmenter and gives the verdict. Depends on yls_pkg,
// yls_ifs, the segmenter and yls_segment_check.

module yuv_lut_color_segmenter_test;

  logic clk;
  logic rst;

  yls_pix_if pix ();
  yls_res_if res ();
  yls_cfg_if cfg ();

  int unsigned fails;
  int unsigned waiting;
  int unsigned checked;
  int unsigned table_writes;

  bit          steady;        // no idling on either side
  bit          hold_pending;  // asks the receiver for one long hold-off
  int unsigned hold_left;

  // indexes already loaded, so a macropixel never reads an unwritten entry
  bit             is_written  [yls_pkg::FUNC_WR_LUMA:yls_pkg::FUNC_WR_V]
                              [yls_pkg::TABLE_DEPTH];
  yls_pkg::byte_t written_idx [yls_pkg::FUNC_WR_LUMA:yls_pkg::FUNC_WR_V][$];

  yls_pkg::mode_e phase_modes [7] = '{yls_pkg::MODE_OVERWRITE_NZ, yls_pkg::MODE_BLEND,
                                      yls_pkg::MODE_PASS, yls_pkg::MODE_OVERWRITE,
                                      yls_pkg::MODE_BLEND, yls_pkg::MODE_OVERWRITE_NZ,
                                      yls_pkg::MODE_PASS};

  yuv_lut_color_segmenter DUT (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  yls_segment_check seg_check (
    .clk          (clk),
    .rst          (rst),
    .pix          (pix),
    .res          (res),
    .cfg          (cfg),
    .fails        (fails),
    .waiting      (waiting),
    .checked      (checked),
    .table_writes (table_writes)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("yuv_lut_color_segmenter_test failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = 80;
      end
      if (hold_left != 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= steady || ($urandom_range(99) >= 36);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic offer_word(yls_pkg::func_e f, yls_pkg::byte_t y0, yls_pkg::byte_t u,
                            yls_pkg::byte_t y1, yls_pkg::byte_t v,
                            yls_pkg::byte_t idx, yls_pkg::byte_t ent);
    while (!steady && $urandom_range(99) < 36) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid       <= 1'b1;
    pix.func        <= f;
    pix.first_luma  <= y0;
    pix.chroma_u    <= u;
    pix.second_luma <= y1;
    pix.chroma_v    <= v;
    pix.table_index <= idx;
    pix.table_entry <= ent;
    do @(posedge clk); while (pix.ready !== 1'b1);
    @(negedge clk);
    if (f != yls_pkg::FUNC_PROCESS && !is_written[f][idx]) begin
      is_written[f][idx] = 1'b1;
      written_idx[f].push_back(idx);
    end
  endtask

  task automatic write_table(yls_pkg::func_e f, yls_pkg::byte_t idx, yls_pkg::byte_t ent);
    offer_word(f, yls_pkg::byte_t'($urandom), yls_pkg::byte_t'($urandom),
               yls_pkg::byte_t'($urandom), yls_pkg::byte_t'($urandom), idx, ent);
  endtask

  task automatic send_macropixel(yls_pkg::byte_t y0, yls_pkg::byte_t u,
                                 yls_pkg::byte_t y1, yls_pkg::byte_t v);
    offer_word(yls_pkg::FUNC_PROCESS, y0, u, y1, v, yls_pkg::byte_t'($urandom),
               yls_pkg::byte_t'($urandom));
  endtask

  function automatic yls_pkg::byte_t pick_written(yls_pkg::func_e f);
    return written_idx[f][$urandom_range(written_idx[f].size() - 1)];
  endfunction

  // mostly full masks and single class bits, so the AND lands on every color
  function automatic yls_pkg::byte_t class_entry();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return 8'hFF;
    if (r < 65) return yls_pkg::byte_t'(1 << $urandom_range(3));
    if (r < 72) return yls_pkg::byte_t'(1 << $urandom_range(7));
    if (r < 80) return 8'h00;
    return yls_pkg::byte_t'($urandom);
  endfunction

  task automatic random_word();
    yls_pkg::func_e f;
    if ($urandom_range(99) < 70) begin
      send_macropixel(pick_written(yls_pkg::FUNC_WR_LUMA), pick_written(yls_pkg::FUNC_WR_U),
                      yls_pkg::byte_t'($urandom), pick_written(yls_pkg::FUNC_WR_V));
    end else begin
      f = yls_pkg::func_e'($urandom_range(yls_pkg::FUNC_WR_LUMA, yls_pkg::FUNC_WR_V));
      write_table(f, yls_pkg::byte_t'($urandom), class_entry());
    end
  endtask

  task automatic set_display_mode(yls_pkg::mode_e m);
    pix.valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    // a trailing table write gives no result word and may still be in flight
    repeat (4) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= m;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    rst             = 1'b1;
    steady          = 1'b0;
    hold_pending    = 1'b0;
    hold_left       = 0;
    pix.valid       = 1'b0;
    pix.func        = yls_pkg::FUNC_PROCESS;
    pix.first_luma  = '0;
    pix.chroma_u    = '0;
    pix.second_luma = '0;
    pix.chroma_v    = '0;
    pix.table_index = '0;
    pix.table_entry = '0;
    res.ready       = 1'b0;
    cfg.valid       = 1'b0;
    cfg.data        = yls_pkg::MODE_OVERWRITE;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: extreme indexes and entries, one macropixel per class color,
    // all under the mode left by reset
    write_table(yls_pkg::FUNC_WR_LUMA, 8'd0, 8'hFF);
    write_table(yls_pkg::FUNC_WR_U, 8'd0, 8'hFF);
    write_table(yls_pkg::FUNC_WR_V, 8'd0, 8'hFF);
    write_table(yls_pkg::FUNC_WR_LUMA, 8'd255, 8'h00);
    write_table(yls_pkg::FUNC_WR_U, 8'd255, 8'hFF);
    write_table(yls_pkg::FUNC_WR_V, 8'd255, 8'hFF);
    write_table(yls_pkg::FUNC_WR_LUMA, 8'd1, 8'h01);
    write_table(yls_pkg::FUNC_WR_LUMA, 8'd2, 8'h02);
    write_table(yls_pkg::FUNC_WR_LUMA, 8'd4, 8'h04);
    write_table(yls_pkg::FUNC_WR_LUMA, 8'd8, 8'h08);
    send_macropixel(8'd0, 8'd0, 8'd0, 8'd0);          // mask outside the color set
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255);  // cleared luma entry: class zero
    send_macropixel(8'd1, 8'd0, 8'd255, 8'd0);
    send_macropixel(8'd2, 8'd255, 8'd127, 8'd255);
    send_macropixel(8'd4, 8'd0, 8'd128, 8'd255);
    send_macropixel(8'd8, 8'd255, 8'd1, 8'd0);

    for (int ph = 0; ph < 7; ph++) begin
      set_display_mode(phase_modes[ph]);
      steady = (ph == 3);
      for (int n = 0; n < 100; n++) begin
        if (ph == 1 && n == 20) hold_pending = 1'b1;
        if (ph == 5 && n == 50) begin
          // sender pauses until the pipeline has drained
          pix.valid <= 1'b0;
          @(negedge clk);
          while (waiting != 0) @(negedge clk);
        end
        random_word();
      end
    end
    steady = 1'b0;
    pix.valid <= 1'b0;

    for (int k = 0; k < 5000 && waiting != 0; k++) @(negedge clk);
    repeat (8) @(negedge clk);

    if (waiting != 0) $display("%0d result words never arrived", waiting);
    $display("checked %0d macropixels after %0d table writes, in all four display modes,",
             checked, table_writes);
    $display("with random stalls, a long result hold-off and a full drain pause");
    if (fails == 0 && waiting == 0) begin
      $display("yuv_lut_color_segmenter_test passed");
    end else begin
      $display("yuv_lut_color_segmenter_test failed");
    end
    $finish;
  end

endmodule
